// File: rtl/core/tga_rle_pkg.sv
// shared types and constants of the tga run-length pixel decoder
package tga_rle_pkg;

  // packet header fields
  localparam logic [7:0] HdrRunBit    = 8'h80;
  localparam logic [6:0] HdrCountMask = 7'd127;

  // register map: word index of each configuration register
  localparam int unsigned RegAddrWidth = 4;
  typedef enum logic [1:0] {
    RegImageWidth    = 2'd0,
    RegImageHeight   = 2'd1,
    RegBytesPerPixel = 2'd2,
    RegUnused        = 2'd3
  } reg_idx_e;

  // pixel size code for four bytes per pixel
  localparam logic [2:0] Bpp4 = 3'd4;

  // one decoded pixel result
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       end_of_image;
    logic       overrun;
  } result_t;

endpackage

// File: rtl/core/tga_rle_pixel_decoder_core.sv
// top level of the tga run-length pixel decoder
//
// Takes one compressed byte per cycle while in_ready_o is high and gives one
// registered result per completed pixel: colour, repeat count (runs are not
// expanded), end-of-image and overrun flags. Every byte is handled by counter
// and compare logic feeding a two-entry output buffer, so the input keeps
// accepting a byte every cycle while a result waits; in_ready_o drops only
// when both buffer entries are full. The pixel total (width times height) is
// formed by a 16x16 multiply at the moment a size register is written, so
// configuration writes take effect at once.
module tga_rle_pixel_decoder_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tga_rle_pkg::RegAddrWidth-1:0] paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // byte input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           in_byte_i,
  // pixel output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [7:0]                           red_o,
  output logic [7:0]                           green_o,
  output logic [7:0]                           blue_o,
  output logic [7:0]                           alpha_o,
  output logic [7:0]                           repeat_count_o,
  output logic                                 end_of_image_o,
  output logic                                 overrun_o
);
  import tga_rle_pkg::*;

  // configuration registers
  logic [15:0] width_q, height_q;
  logic [2:0]  bpp_q;
  logic [31:0] total_q;

  // decoder state
  logic        expect_header_q;
  logic        packet_is_run_q;
  logic        packet_clipped_q;
  logic [7:0]  packet_left_q;
  logic [1:0]  byte_pos_q;
  logic [7:0]  held_q [3];
  logic [31:0] pixels_done_q;

  // output buffer
  logic        out_valid_q, skid_valid_q;
  result_t     out_q, skid_q;

  // register access
  reg_idx_e    reg_idx;
  logic        cfg_wr;
  logic [15:0] wdata_fix, width_fix, height_fix;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[RegAddrWidth-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  // zero size counts as one
  assign wdata_fix  = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
  assign width_fix  = (width_q == 16'd0) ? 16'd1 : width_q;
  assign height_fix = (height_q == 16'd0) ? 16'd1 : height_q;

  // register read mux
  always_comb begin
    case (reg_idx)
      RegImageWidth:    prdata = {16'd0, width_q};
      RegImageHeight:   prdata = {16'd0, height_q};
      RegBytesPerPixel: prdata = {29'd0, bpp_q};
      default:          prdata = 32'd0;
    endcase
  end

  // register writes, pixel total recomputed with the new size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1;
      height_q <= 16'd1;
      bpp_q    <= 3'd3;
      total_q  <= 32'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegImageWidth: begin
          width_q <= pwdata[15:0];
          total_q <= 32'(wdata_fix) * 32'(height_fix);
        end
        RegImageHeight: begin
          height_q <= pwdata[15:0];
          total_q  <= 32'(width_fix) * 32'(wdata_fix);
        end
        RegBytesPerPixel: bpp_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // byte decode
  logic        accept, push, pop;
  logic        four_bytes;
  logic [32:0] diff;
  logic        done_reached;
  logic [31:0] remaining;
  logic [7:0]  hdr_count;
  logic        hdr_clip;
  logic [2:0]  pos_inc;
  logic        pixel_end;
  logic [7:0]  rep;
  logic        last;
  logic [7:0]  red_new;
  result_t     res;

  assign in_ready_o = ~skid_valid_q;
  assign accept     = in_valid_i & in_ready_o;
  assign four_bytes = (bpp_q == Bpp4);

  // pixels left in the image, done count at or past the total means finished
  assign diff         = {1'b0, total_q} - {1'b0, pixels_done_q};
  assign done_reached = diff[32] | (diff[31:0] == 32'd0);
  assign remaining    = done_reached ? total_q : diff[31:0];

  // header count and clipping
  assign hdr_count = {1'b0, in_byte_i[6:0] & HdrCountMask} + 8'd1;
  assign hdr_clip  = 32'(hdr_count) > remaining;

  // pixel byte position
  assign pos_inc   = {1'b0, byte_pos_q} + 3'd1;
  assign pixel_end = ~expect_header_q & (pos_inc >= (four_bytes ? 3'd4 : 3'd3));

  // repeat count and end of image
  assign rep     = (packet_is_run_q && packet_left_q != 8'd0) ? packet_left_q : 8'd1;
  assign last    = done_reached | (diff[31:0] <= 32'(rep));
  assign red_new = four_bytes ? held_q[2] : in_byte_i;

  always_comb begin
    res.red          = red_new;
    res.green        = held_q[1];
    res.blue         = held_q[0];
    res.alpha        = four_bytes ? in_byte_i : 8'd0;
    res.repeat_count = rep;
    res.end_of_image = last;
    res.overrun      = packet_clipped_q;
  end

  assign push = accept & pixel_end;
  assign pop  = out_valid_q & out_ready_i;

  // decoder state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_header_q  <= 1'b1;
      packet_is_run_q  <= 1'b0;
      packet_clipped_q <= 1'b0;
      packet_left_q    <= 8'd0;
      byte_pos_q       <= 2'd0;
      held_q           <= '{default: 8'd0};
      pixels_done_q    <= 32'd0;
    end else if (accept) begin
      if (expect_header_q) begin
        if (done_reached) pixels_done_q <= 32'd0;
        packet_is_run_q  <= (in_byte_i & HdrRunBit) != 8'd0;
        packet_clipped_q <= hdr_clip;
        packet_left_q    <= hdr_clip ? remaining[7:0] : hdr_count;
        byte_pos_q       <= 2'd0;
        expect_header_q  <= 1'b0;
      end else if (!pixel_end) begin
        if (byte_pos_q != 2'd3) held_q[byte_pos_q] <= in_byte_i;
        byte_pos_q <= pos_inc[1:0];
      end else begin
        held_q[2]  <= red_new;
        byte_pos_q <= 2'd0;
        if (last) begin
          pixels_done_q   <= 32'd0;
          expect_header_q <= 1'b1;
          packet_left_q   <= 8'd0;
        end else begin
          pixels_done_q <= pixels_done_q + 32'(rep);
          if (packet_is_run_q || packet_left_q <= 8'd1) begin
            packet_left_q   <= 8'd0;
            expect_header_q <= 1'b1;
          end else begin
            packet_left_q <= packet_left_q - 8'd1;
          end
        end
      end
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push && out_valid_q && !pop) begin
      skid_valid_q <= 1'b1;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push && out_valid_q && !pop) begin
      skid_q <= res;
    end else if (push) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_o          = out_q.red;
  assign green_o        = out_q.green;
  assign blue_o         = out_q.blue;
  assign alpha_o        = out_q.alpha;
  assign repeat_count_o = out_q.repeat_count;
  assign end_of_image_o = out_q.end_of_image;
  assign overrun_o      = out_q.overrun;

  // second buffer entry only fills behind the first
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while head entry empty");

  // a packet in progress always has pixels left, a finished one none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    expect_header_q |-> packet_left_q == 8'd0)
    else $error("pixels left while awaiting a header");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !expect_header_q |-> packet_left_q != 8'd0)
    else $error("packet in progress with no pixels left");

  // repeat count stays within a packet's span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (repeat_count_o != 8'd0) && (repeat_count_o <= 8'd128))
    else $error("repeat count out of range");

endmodule
